// File: rtl/core/i2ctrf_pkg.sv
// ----------------------------------------------------------------------------
// i2ctrf_pkg
// Shared types, codes and helpers for the I2C target register file.
// ----------------------------------------------------------------------------
package i2ctrf_pkg;

    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int RESULT_W  = 48;
    localparam int DEPTH_W   = 9;
    localparam int RECIP_W   = 13;

    // Bus events
    typedef enum logic [CMD_W-1:0] {
        CMD_ADDR  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_INDEX = 2'd2;

    localparam logic [BYTE_W-1:0] MOTOR_BASE_RST = 8'd0;
    localparam logic [BYTE_W-1:0] LOW_BASE_RST   = 8'd4;
    localparam logic [BYTE_W-1:0] CTRL_INDEX_RST = 8'd8;

    // Magnet control byte values
    localparam logic [BYTE_W-1:0] CTRL_CLEAR  = 8'd0;
    localparam logic [BYTE_W-1:0] CTRL_SET    = 8'd1;
    localparam logic [BYTE_W-1:0] CTRL_TOGGLE = 8'd2;

    localparam int WIN_BYTES = 4;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    // Window bookkeeping handed from the shadow unit to the top level.
    typedef struct packed {
        logic              busy;
        logic [BYTE_W-1:0] motor_top;
        logic [BYTE_W-1:0] low_top;
        logic [23:0]       motor_bytes;
        logic [23:0]       low_bytes;
    } win_info_t;

    // Result beat, packed from the lowest bit up (first member is the MSB).
    typedef struct packed {
        logic [2:0]  pad;
        logic        low_mag_level;
        logic [31:0] count_value;
        logic        low_mag_count_load;
        logic        motor_count_load;
        logic        encoder_refresh;
        logic [7:0]  read_data;
        logic        read_valid;
    } result_t;

    typedef enum logic [1:0] {
        SW_IDLE,
        SW_READ,
        SW_WAIT
    } sweep_state_t;

    // Index modulo the store depth, by reciprocal multiply and one correction.
    // The reciprocal is rounded down, so the first remainder lies below twice
    // the depth.
    function automatic logic [BYTE_W-1:0] wrap_idx(
        input logic [DEPTH_W-1:0] x,
        input logic [DEPTH_W-1:0] depth,
        input logic [RECIP_W-1:0] recip
    );
        logic [21:0] prod;
        logic [8:0]  quot;
        logic [17:0] qd;
        logic [9:0]  rem;
        prod = 22'(x) * 22'(recip);
        quot = prod[16 +: 9] & 9'h1FF;
        qd   = 18'(quot) * 18'(depth);
        rem  = 10'(x) - 10'(qd);
        if (rem >= 10'(depth)) begin
            rem = rem - 10'(depth);
        end
        return BYTE_W'(rem);
    endfunction

endpackage

// File: rtl/core/i2ctrf_store.sv
// ----------------------------------------------------------------------------
// i2ctrf_store
// Register byte store: one write port, two registered read ports, and a
// valid bit per entry so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module i2ctrf_store #(
    parameter int STORE_DEPTH = 256,
    parameter int AW          = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  i2ctrf_pkg::store_wr_t            wr,
    input  logic [AW-1:0]                    rda_addr,
    output logic [i2ctrf_pkg::BYTE_W-1:0]    rda_data,
    input  logic [AW-1:0]                    rdb_addr,
    output logic [i2ctrf_pkg::BYTE_W-1:0]    rdb_data
);
    import i2ctrf_pkg::*;

    logic [BYTE_W-1:0]      store_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [BYTE_W-1:0]      rda_mem_reg;
    logic [BYTE_W-1:0]      rdb_mem_reg;
    logic                   rda_vld_reg;
    logic                   rdb_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            store_mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rda_mem_reg <= store_mem[rda_addr];
        rdb_mem_reg <= store_mem[rdb_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            rda_vld_reg <= 1'b0;
            rdb_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            rda_vld_reg <= vld_reg[rda_addr];
            rdb_vld_reg <= vld_reg[rdb_addr];
        end
    end

    assign rda_data = rda_vld_reg ? rda_mem_reg : '0;
    assign rdb_data = rdb_vld_reg ? rdb_mem_reg : '0;

endmodule

// File: rtl/core/i2ctrf_shadow.sv
// ----------------------------------------------------------------------------
// i2ctrf_shadow
// Keeps copies of the two counter windows so a write to a window's top byte
// can emit the whole 32-bit value at once. After a base change the copies are
// reloaded from the store's second read port.
// ----------------------------------------------------------------------------
module i2ctrf_shadow #(
    parameter int STORE_DEPTH = 256,
    parameter int AW          = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [i2ctrf_pkg::BYTE_W-1:0]    motor_base,
    input  logic [i2ctrf_pkg::BYTE_W-1:0]    low_base,
    input  i2ctrf_pkg::store_wr_t            wr,
    output logic [AW-1:0]                    rdb_addr,
    input  logic [i2ctrf_pkg::BYTE_W-1:0]    rdb_data,
    output i2ctrf_pkg::win_info_t            win
);
    import i2ctrf_pkg::*;

    localparam logic [DEPTH_W-1:0] DepthW = DEPTH_W'(STORE_DEPTH);
    localparam logic [RECIP_W-1:0] RecipW = RECIP_W'(65536 / STORE_DEPTH);

    logic [BYTE_W-1:0] m_addr [WIN_BYTES];
    logic [BYTE_W-1:0] l_addr [WIN_BYTES];
    logic [BYTE_W-1:0] mot_sh_reg [WIN_BYTES];
    logic [BYTE_W-1:0] low_sh_reg [WIN_BYTES];

    sweep_state_t state_reg, state_next;
    logic [2:0]   slot_reg, slot_next;
    logic         cap_vld_reg;
    logic [2:0]   cap_slot_reg;
    logic         issue;

    always_comb begin
        for (int k = 0; k < WIN_BYTES; k++) begin
            m_addr[k] = wrap_idx(DEPTH_W'(motor_base) + DEPTH_W'(k), DepthW, RecipW);
            l_addr[k] = wrap_idx(DEPTH_W'(low_base) + DEPTH_W'(k), DepthW, RecipW);
        end
    end

    // Next state: eight reads (two windows of four bytes), then a wait state for
    // the last read to land. A new base restarts the pass.
    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        case (state_reg)
            SW_IDLE: begin
            end
            SW_READ: begin
                slot_next = slot_reg + 3'd1;
                if (slot_reg == 3'd7) begin
                    state_next = SW_WAIT;
                end
            end
            SW_WAIT: begin
                state_next = SW_IDLE;
            end
            default: begin
                state_next = SW_IDLE;
            end
        endcase
        if (start) begin
            state_next = SW_READ;
            slot_next  = 3'd0;
        end
    end

    always_comb begin
        issue    = (state_reg == SW_READ);
        rdb_addr = slot_reg[2] ? l_addr[slot_reg[1:0]][AW-1:0] : m_addr[slot_reg[1:0]][AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SW_IDLE;
            slot_reg     <= 3'd0;
            cap_vld_reg  <= 1'b0;
            cap_slot_reg <= 3'd0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            cap_vld_reg  <= issue;
            cap_slot_reg <= slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WIN_BYTES; k++) begin
                mot_sh_reg[k] <= '0;
                low_sh_reg[k] <= '0;
            end
        end else begin
            if (cap_vld_reg) begin
                if (cap_slot_reg[2]) begin
                    low_sh_reg[cap_slot_reg[1:0]] <= rdb_data;
                end else begin
                    mot_sh_reg[cap_slot_reg[1:0]] <= rdb_data;
                end
            end
            // Stores keep the copies current; the windows may overlap.
            if (wr.en) begin
                for (int k = 0; k < WIN_BYTES; k++) begin
                    if (wr.addr == m_addr[k]) begin
                        mot_sh_reg[k] <= wr.data;
                    end
                    if (wr.addr == l_addr[k]) begin
                        low_sh_reg[k] <= wr.data;
                    end
                end
            end
        end
    end

    assign win.busy        = (state_reg != SW_IDLE);
    assign win.motor_top   = m_addr[WIN_BYTES-1];
    assign win.low_top     = l_addr[WIN_BYTES-1];
    assign win.motor_bytes = {mot_sh_reg[2], mot_sh_reg[1], mot_sh_reg[0]};
    assign win.low_bytes   = {low_sh_reg[2], low_sh_reg[1], low_sh_reg[0]};

endmodule

// File: rtl/core/i2c_target_register_file_unit.sv
// ----------------------------------------------------------------------------
// i2c_target_register_file_unit
// Register map behind an I2C target with an auto-incrementing pointer,
// counter preset windows with load strobes, and a magnet control output.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Carries
//  s_axis   | in        | tuser: cmd; tdata: rx_byte
//  m_axis   | out       | tdata: read_valid .. low_mag_level (one beat per event)
//  cfg      | in        | cfg_index selects a register, cfg_data is its value
//
// An event beat is taken into the input register, handled there, and its result
// beat is shown in the output register: one beat per cycle sustained while the
// output is not stalled and no configuration write or reload holds the input. Reads use the store's first read
// port, which always holds the byte at the current pointer.
// After a write to either base register the input stalls while
// the window copies reload through the store's second read port.
// Reset is synchronous; the store reads as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module i2c_target_register_file_unit #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [i2ctrf_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] rx_byte
    input  logic [i2ctrf_pkg::CMD_W-1:0]        s_axis_tuser,   // [1:0] cmd
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] read_valid, [8:1] read_data, [9] encoder_refresh,
    // [10] motor_count_load, [11] low_mag_count_load, [43:12] count_value,
    // [44] low_mag_level, [47:45] zero
    output logic [i2ctrf_pkg::RESULT_W-1:0]     m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2ctrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2ctrf_pkg::BYTE_W-1:0]       cfg_data
);
    import i2ctrf_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [DEPTH_W-1:0] DepthW  = DEPTH_W'(STORE_DEPTH);
    localparam logic [RECIP_W-1:0] RecipW  = RECIP_W'(65536 / STORE_DEPTH);
    localparam logic [AW-1:0]      PtrLast = AW'(STORE_DEPTH - 1);

    logic [BYTE_W-1:0] mbase_reg, lbase_reg, ctrl_idx_reg;

    logic              in_vld_reg;
    cmd_t              in_cmd_reg;
    logic [BYTE_W-1:0] in_rx_reg;

    logic [AW-1:0]     ptr_reg, ptr_next, ptr_inc;
    logic              exp_idx_reg, exp_idx_next;
    logic              exp_data_reg, exp_data_next;
    logic              level_reg, level_next;

    logic              out_vld_reg;
    result_t           out_data_reg;
    result_t           res;

    logic              proc;
    logic              s_fire;
    logic              sweep_start;
    store_wr_t         wr;
    win_info_t         win;
    logic [AW-1:0]     rdb_addr;
    logic [BYTE_W-1:0] rda_data, rdb_data;
    logic [BYTE_W-1:0] rx_addr, ctrl_addr;

    assign cfg_ready     = 1'b1;
    assign sweep_start   = cfg_valid && ((cfg_index == CFG_MOTOR_BASE) ||
                                         (cfg_index == CFG_LOW_BASE));
    assign proc          = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = (!in_vld_reg || proc) && !win.busy && !cfg_valid;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign rx_addr   = wrap_idx(DEPTH_W'(in_rx_reg), DepthW, RecipW);
    assign ctrl_addr = wrap_idx(DEPTH_W'(ctrl_idx_reg), DepthW, RecipW);
    assign ptr_inc   = (ptr_reg == PtrLast) ? '0 : ptr_reg + AW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbase_reg    <= MOTOR_BASE_RST;
            lbase_reg    <= LOW_BASE_RST;
            ctrl_idx_reg <= CTRL_INDEX_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MOTOR_BASE: mbase_reg    <= cfg_data;
                CFG_LOW_BASE:   lbase_reg    <= cfg_data;
                CFG_CTRL_INDEX: ctrl_idx_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Event handling for the beat in the input register.
    always_comb begin
        ptr_next      = ptr_reg;
        exp_idx_next  = exp_idx_reg;
        exp_data_next = exp_data_reg;
        level_next    = level_reg;
        wr            = '0;
        res           = '0;
        if (proc) begin
            case (in_cmd_reg)
                CMD_ADDR: begin
                    exp_idx_next        = 1'b1;
                    exp_data_next       = 1'b0;
                    res.encoder_refresh = 1'b1;
                end
                CMD_WRITE: begin
                    if (exp_idx_reg) begin
                        ptr_next      = rx_addr[AW-1:0];
                        exp_idx_next  = 1'b0;
                        exp_data_next = 1'b1;
                    end else if (exp_data_reg) begin
                        wr.en   = 1'b1;
                        wr.addr = BYTE_W'(ptr_reg);
                        wr.data = in_rx_reg;
                        // The motor window wins over the second window, which
                        // wins over the control index.
                        if (wr.addr == win.motor_top) begin
                            res.motor_count_load = 1'b1;
                            res.count_value      = {in_rx_reg, win.motor_bytes};
                        end else if (wr.addr == win.low_top) begin
                            res.low_mag_count_load = 1'b1;
                            res.count_value        = {in_rx_reg, win.low_bytes};
                        end else if (wr.addr == ctrl_addr) begin
                            case (in_rx_reg)
                                CTRL_CLEAR:  level_next = 1'b0;
                                CTRL_SET:    level_next = 1'b1;
                                CTRL_TOGGLE: level_next = ~level_reg;
                                default: begin
                                end
                            endcase
                        end
                        ptr_next = ptr_inc;
                    end
                end
                CMD_READ: begin
                    res.read_valid = 1'b1;
                    res.read_data  = rda_data;
                    ptr_next       = ptr_inc;
                end
                default: begin
                end
            endcase
            res.low_mag_level = level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            ptr_reg      <= '0;
            exp_idx_reg  <= 1'b0;
            exp_data_reg <= 1'b0;
            level_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                in_vld_reg <= 1'b1;
            end else if (proc) begin
                in_vld_reg <= 1'b0;
            end
            ptr_reg      <= ptr_next;
            exp_idx_reg  <= exp_idx_next;
            exp_data_reg <= exp_data_next;
            level_reg    <= level_next;
            if (proc) begin
                out_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg <= cmd_t'(s_axis_tuser);
            in_rx_reg  <= s_axis_tdata;
        end
        if (proc) begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // The first read port follows the pointer, so its data is always the byte
    // at the pointer by the time the next beat is handled.
    i2ctrf_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .rda_addr (ptr_next),
        .rda_data (rda_data),
        .rdb_addr (rdb_addr),
        .rdb_data (rdb_data)
    );

    i2ctrf_shadow #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_shadow (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (sweep_start),
        .motor_base (mbase_reg),
        .low_base   (lbase_reg),
        .wr         (wr),
        .rdb_addr   (rdb_addr),
        .rdb_data   (rdb_data),
        .win        (win)
    );

endmodule

// File: rtl/core/i2ctrf_checker.sv
// ----------------------------------------------------------------------------
// i2ctrf_checker
// Port-level checks for the register file unit, bound to the top level.
// ----------------------------------------------------------------------------
module i2ctrf_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [i2ctrf_pkg::RESULT_W-1:0]     m_axis_tdata,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [i2ctrf_pkg::CFG_IDX_W-1:0]    cfg_index
);
    import i2ctrf_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Every accepted event is followed by a valid result beat on the output.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("accepted event produced no result beat");

    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> !s_axis_tready)
        else $error("event taken during a configuration write");

    // A base change reloads the window copies before the next event.
    a_base_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready &&
        (cfg_index == CFG_MOTOR_BASE || cfg_index == CFG_LOW_BASE)
        |=> !s_axis_tready)
        else $error("event taken while window copies reload");

endmodule

bind i2c_target_register_file_unit i2ctrf_checker u_checker (.*);

// File: verif/tb_i2c_target_register_file_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_target_register_file_unit
// Self-checking bench for the I2C target register file. Bus events are driven
// as stream beats with random gaps while the result side stalls at random. A
// shadow copy of the register map predicts every result beat, and the beats
// are checked in order. The counter windows and the control index are moved
// between traffic phases, from the extremes to overlapping settings.
// ----------------------------------------------------------------------------
module tb_i2c_target_register_file_unit;
    import i2ctrf_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int LONG_HOLD   = 200;
    localparam int TIMEOUT_NS  = 15_000_000;
    localparam int PHASE_EVENTS = 215;

    // The bus event code that the block does not define.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    class regfile_shadow;
        logic [BYTE_W-1:0] motor_base;
        logic [BYTE_W-1:0] low_base;
        logic [BYTE_W-1:0] ctrl_index;
        logic [BYTE_W-1:0] store [STORE_DEPTH];
        logic [BYTE_W-1:0] pointer;
        bit                arm_index;
        bit                arm_data;
        bit                level;
        result_t           pending_beats [$];
        int                mismatches;

        function new();
            motor_base = MOTOR_BASE_RST;
            low_base   = LOW_BASE_RST;
            ctrl_index = CTRL_INDEX_RST;
            foreach (store[i]) store[i] = '0;
            pointer    = '0;
            arm_index  = 1'b0;
            arm_data   = 1'b0;
            level      = 1'b0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                CFG_MOTOR_BASE: motor_base = val;
                CFG_LOW_BASE:   low_base   = val;
                CFG_CTRL_INDEX: ctrl_index = val;
                default: ;
            endcase
        endfunction

        function logic [31:0] window_word(logic [BYTE_W-1:0] base);
            logic [31:0]       word;
            logic [BYTE_W-1:0] idx;
            word = '0;
            for (int k = 0; k < WIN_BYTES; k++) begin
                idx = base + BYTE_W'(k);
                word[8*k +: 8] = store[idx];
            end
            return word;
        endfunction

        // Returns 1 when the event does something, 0 when the block ignores it.
        function bit apply_event(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] rx);
            result_t           beat;
            bit                taken;
            logic [BYTE_W-1:0] motor_top;
            logic [BYTE_W-1:0] low_top;
            beat      = '0;
            taken     = 1'b1;
            motor_top = motor_base + 8'd3;
            low_top   = low_base + 8'd3;
            case (cmd)
                CMD_ADDR: begin
                    arm_index = 1'b1;
                    arm_data  = 1'b0;
                    beat.encoder_refresh = 1'b1;
                end
                CMD_WRITE: begin
                    if (arm_index) begin
                        pointer   = rx;
                        arm_index = 1'b0;
                        arm_data  = 1'b1;
                    end else if (arm_data) begin
                        store[pointer] = rx;
                        // The motor window wins over the second window, which
                        // wins over the control index.
                        if (pointer == motor_top) begin
                            beat.motor_count_load = 1'b1;
                            beat.count_value      = window_word(motor_base);
                        end else if (pointer == low_top) begin
                            beat.low_mag_count_load = 1'b1;
                            beat.count_value        = window_word(low_base);
                        end else if (pointer == ctrl_index) begin
                            if (rx == CTRL_CLEAR) level = 1'b0;
                            else if (rx == CTRL_SET) level = 1'b1;
                            else if (rx == CTRL_TOGGLE) level = ~level;
                        end
                        pointer = pointer + 8'd1;
                    end else begin
                        taken = 1'b0;
                    end
                end
                CMD_READ: begin
                    beat.read_valid = 1'b1;
                    beat.read_data  = store[pointer];
                    pointer = pointer + 8'd1;
                end
                default: taken = 1'b0;
            endcase
            beat.low_mag_level = level;
            pending_beats.push_back(beat);
            return taken;
        endfunction

        function string beat_text(result_t b);
            return $sformatf("rv=%0d rd=%02h refresh=%0d mload=%0d lload=%0d cv=%08h lvl=%0d pad=%0h",
                             b.read_valid, b.read_data, b.encoder_refresh, b.motor_count_load,
                             b.low_mag_count_load, b.count_value, b.low_mag_level, b.pad);
        endfunction

        function void check_beat(logic [RESULT_W-1:0] raw);
            result_t got;
            result_t want;
            got = result_t'(raw);
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat: %s", $time, beat_text(got));
                return;
            end
            want = pending_beats.pop_front();
            if (got.read_valid !== want.read_valid || got.read_data !== want.read_data ||
                got.encoder_refresh !== want.encoder_refresh ||
                got.motor_count_load !== want.motor_count_load ||
                got.low_mag_count_load !== want.low_mag_count_load ||
                got.count_value !== want.count_value ||
                got.low_mag_level !== want.low_mag_level || got.pad !== want.pad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result mismatch", $time);
                    $display("    expected %s", beat_text(want));
                    $display("    actual   %s", beat_text(got));
                end
            end
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata;
    logic [CMD_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [RESULT_W-1:0]  m_axis_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    regfile_shadow shadow;
    int            events_taken = 0;
    int            burst_left = 0;
    bit            hold_off_req = 1'b0;

    i2c_target_register_file_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            shadow.check_beat(m_axis_tdata);
        end
    end

    // Result side: mostly ready, with short stalls, some open stretches, rare long ones,
    // and one forced hold-off that lets the block back up into its input.
    initial begin
        int r;
        forever begin
            r = $urandom_range(0, 99);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (r < 55) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end else if (r < 62) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end else if (r < 96) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_i2c_target_register_file_unit: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if (r < 3) burst_left = $urandom_range(20, 80);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Index bytes land near the window tops and the control index most of the time.
    function automatic logic [BYTE_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return shadow.motor_base + BYTE_W'($urandom_range(0, 3));
        if (r < 50) return shadow.low_base + BYTE_W'($urandom_range(0, 3));
        if (r < 65) return shadow.ctrl_index;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_data();
        if ($urandom_range(0, 99) < 30) return BYTE_W'($urandom_range(0, 3));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] rx);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= rx;
        do @(posedge aclk); while (!s_axis_tready);
        if (shadow.apply_event(cmd, rx)) events_taken++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (shadow.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        shadow.set_register(idx, val);
    endtask

    task automatic configure(input logic [BYTE_W-1:0] motor, input logic [BYTE_W-1:0] low,
                             input logic [BYTE_W-1:0] ctrl);
        drain_results();
        write_reg(CFG_MOTOR_BASE, motor);
        write_reg(CFG_LOW_BASE, low);
        write_reg(CFG_CTRL_INDEX, ctrl);
        cfg_valid <= 1'b0;
    endtask

    // Mostly complete transfers with random content, the rest noise.
    task automatic run_traffic(input int target);
        int start;
        int kind;
        int n;
        start = events_taken;
        while (events_taken - start < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                send_event(CMD_ADDR, BYTE_W'($urandom_range(0, 255)));
                send_event(CMD_WRITE, pick_index());
                n = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
                repeat (n) send_event(CMD_WRITE, pick_data());
            end else if (kind < 85) begin
                send_event(CMD_ADDR, BYTE_W'($urandom_range(0, 255)));
                send_event(CMD_WRITE, pick_index());
                repeat ($urandom_range(1, 8))
                    send_event(CMD_READ, BYTE_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_event(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        shadow = new();
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_ADDR;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_MOTOR_BASE;
        cfg_data      <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset layout: motor window 0..3, second window 4..7, control at 8.
        send_event(CMD_READ, 8'hFF);     // read before any index byte
        send_event(CMD_WRITE, 8'hFF);    // data byte while not armed
        send_event(CMD_UNUSED, 8'hFF);
        send_event(CMD_ADDR, 8'h00);
        send_event(CMD_WRITE, 8'h00);
        send_event(CMD_WRITE, 8'h11);
        send_event(CMD_WRITE, 8'h22);
        send_event(CMD_WRITE, 8'h33);
        send_event(CMD_WRITE, 8'h80);    // motor window top
        send_event(CMD_WRITE, 8'hAA);
        send_event(CMD_WRITE, 8'h55);
        send_event(CMD_WRITE, 8'hFF);
        send_event(CMD_WRITE, 8'h00);    // second window top
        send_event(CMD_WRITE, CTRL_SET);
        send_event(CMD_ADDR, 8'h00);
        send_event(CMD_WRITE, CTRL_INDEX_RST);
        send_event(CMD_WRITE, CTRL_CLEAR);
        send_event(CMD_ADDR, 8'h00);
        send_event(CMD_WRITE, CTRL_INDEX_RST);
        send_event(CMD_WRITE, CTRL_TOGGLE);
        send_event(CMD_ADDR, 8'h00);
        send_event(CMD_WRITE, CTRL_INDEX_RST);
        send_event(CMD_WRITE, 8'h7E);    // other values are only stored
        send_event(CMD_ADDR, 8'h00);
        send_event(CMD_WRITE, 8'hFF);
        send_event(CMD_WRITE, 8'h5A);    // pointer wraps past the last index
        send_event(CMD_READ, 8'h00);

        hold_off_req = 1'b1;
        burst_left   = 80;
        run_traffic(PHASE_EVENTS);

        configure(8'd252, 8'd0, 8'd255);
        run_traffic(PHASE_EVENTS);
        configure(8'd0, 8'd252, 8'd0);
        run_traffic(PHASE_EVENTS);
        configure(8'd16, 8'd16, 8'd19);  // both windows and the control coincide
        run_traffic(PHASE_EVENTS);
        configure(8'd100, 8'd102, 8'd101);
        run_traffic(PHASE_EVENTS);
        repeat (3) begin
            configure(BYTE_W'($urandom_range(0, 252)), BYTE_W'($urandom_range(0, 252)),
                      BYTE_W'($urandom_range(0, 255)));
            run_traffic(PHASE_EVENTS);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("tb_i2c_target_register_file_unit: done, clean");
        end else begin
            $display("tb_i2c_target_register_file_unit: done, errors");
        end
        $finish;
    end

endmodule
